>>> rtl/lpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_pkg
// shared constants and the token type that travels along the lookup chain
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned LprTableDepth = 256;

  localparam int unsigned IdxW  = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned PortW = 4;
  localparam int unsigned LiveW = 9;

  // operation codes of an input item
  localparam logic OpWrite  = 1'b0;
  localparam logic OpLookup = 1'b1;

  // register word index on the configuration port
  localparam logic RegLiveEntries = 1'b0;

  // one token per chain stage
  // write:  key = prefix, mask = mask, hop/port = entry data
  // lookup: key = address, mask/hop/port/found = best match so far
  typedef struct packed {
    logic             valid;
    logic             op;
    logic [IdxW-1:0]  index;
    logic [AddrW-1:0] key;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] hop;
    logic [PortW-1:0] port;
    logic             found;
  } lpr_tok_t;

endpackage
`default_nettype wire

>>> rtl/lpr_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_req_if / lpr_rsp_if
// valid/ready channels for table writes and lookups, and for lookup results
// ----------------------------------------------------------------------------
interface lpr_req_if;
  import lpr_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [IdxW-1:0]  entry_index;
  logic [AddrW-1:0] entry_prefix;
  logic [AddrW-1:0] entry_mask;
  logic [AddrW-1:0] entry_gateway;
  logic [PortW-1:0] entry_port;
  logic [AddrW-1:0] lookup_address;

  modport source (
    output valid, operation, entry_index, entry_prefix, entry_mask,
           entry_gateway, entry_port, lookup_address,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_prefix, entry_mask,
           entry_gateway, entry_port, lookup_address,
    output ready
  );
endinterface

interface lpr_rsp_if;
  import lpr_pkg::*;

  logic             valid;
  logic             ready;
  logic             route_found;
  logic [AddrW-1:0] gateway;
  logic [PortW-1:0] out_port;

  modport source (output valid, route_found, gateway, out_port, input ready);
  modport sink (input valid, route_found, gateway, out_port, output ready);
endinterface
`default_nettype wire

>>> rtl/longest_prefix_route_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// ipv4 longest-prefix routing table built as a chain of per-slot cells
// ----------------------------------------------------------------------------
// Each of the TableDepth slots is a cell holding one entry. Every input item,
// write or lookup, enters cell 0 and moves one cell per cycle while the chain
// advances, so one item is taken per cycle unless the chain holds; a lookup
// sees exactly the writes transferred before it. The first cell loads an item
// on its transfer edge itself; the token then passes through the rest of the
// cell chain and then the result register, which shows the result; write
// items give no result. The whole chain holds while a result waits on the
// output. Slots at or beyond live_entries (APB word 0) take no part in lookups;
// writes to a slot at or beyond TableDepth are dropped.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup #(
  parameter int unsigned TableDepth = lpr_pkg::LprTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lpr_req_if.sink          in_i,
  lpr_rsp_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import lpr_pkg::*;

  logic [LiveW-1:0] live_q;
  logic             advance;
  lpr_tok_t         chain [TableDepth+1];

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLiveEntries) ? 32'(live_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == RegLiveEntries)) begin
      live_q <= pwdata[LiveW-1:0];
    end
  end

  // head token
  assign in_i.ready = advance;

  always_comb begin
    chain[0].valid = in_i.valid;
    chain[0].op    = in_i.operation;
    chain[0].index = in_i.entry_index;
    if (in_i.operation == OpWrite) begin
      chain[0].key   = in_i.entry_prefix;
      chain[0].mask  = in_i.entry_mask;
      chain[0].hop   = in_i.entry_gateway;
      chain[0].port  = in_i.entry_port;
    end else begin
      chain[0].key   = in_i.lookup_address;
      chain[0].mask  = '0;
      chain[0].hop   = '0;
      chain[0].port  = '0;
    end
    chain[0].found = 1'b0;
  end

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    logic live;
    assign live = (32'(live_q) > 32'(i));

    lpr_cell #(
      .CellIdx (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .live_i    (live),
      .tok_i     (chain[i]),
      .tok_o     (chain[i+1])
    );
  end

  lpr_outreg u_outreg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tail_i    (chain[TableDepth]),
    .advance_o (advance),
    .rsp       (out_o)
  );

endmodule
`default_nettype wire

>>> rtl/lpr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_cell
// one table slot: stores its entry and updates the best match of a passing
// lookup token
// ----------------------------------------------------------------------------
module lpr_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire logic              live_i,
  input  wire lpr_pkg::lpr_tok_t tok_i,
  output lpr_pkg::lpr_tok_t      tok_o
);
  import lpr_pkg::*;

  logic [AddrW-1:0] prefix_q;
  logic [AddrW-1:0] mask_q;
  logic [AddrW-1:0] hop_q;
  logic [PortW-1:0] port_q;

  logic     valid_q;
  lpr_tok_t tok_q;
  lpr_tok_t tok_d;
  logic     wr_hit;
  logic     match;
  logic     better;

  assign wr_hit = tok_i.valid && (tok_i.op == OpWrite) && (32'(tok_i.index) == CellIdx);
  assign match  = live_i && ((tok_i.key & mask_q) == prefix_q);
  // strictly greater keeps the lower slot on equal masks
  assign better = tok_i.valid && (tok_i.op == OpLookup) && match &&
                  (!tok_i.found || (mask_q > tok_i.mask));

  always_comb begin
    tok_d = tok_i;
    if (better) begin
      tok_d.found = 1'b1;
      tok_d.mask  = mask_q;
      tok_d.hop   = hop_q;
      tok_d.port  = port_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && wr_hit) begin
      prefix_q <= tok_i.key;
      mask_q   <= tok_i.mask;
      hop_q    <= tok_i.hop;
      port_q   <= tok_i.port;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule
`default_nettype wire

>>> rtl/lpr_outreg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_outreg
// result register at the end of the chain; drops write tokens and stalls the
// chain while a result waits
// ----------------------------------------------------------------------------
module lpr_outreg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lpr_pkg::lpr_tok_t tail_i,
  output logic                   advance_o,
  lpr_rsp_if.source              rsp
);
  import lpr_pkg::*;

  logic             out_valid_q;
  logic             found_q;
  logic [AddrW-1:0] hop_q;
  logic [PortW-1:0] port_q;
  logic             take;

  assign advance_o = !out_valid_q || rsp.ready;
  assign take      = tail_i.valid && (tail_i.op == OpLookup);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && take) begin
      found_q <= tail_i.found;
      hop_q   <= tail_i.found ? tail_i.hop : '0;
      port_q  <= tail_i.found ? tail_i.port : '0;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.route_found = found_q;
  assign rsp.gateway     = hop_q;
  assign rsp.out_port    = port_q;

  // write tokens leave the chain without a result
  a_write_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && !take) |=> !out_valid_q)
    else $error("result raised by a write token");

  // a lookup at the tail always lands in the result register
  a_lookup_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_o && take) |=> out_valid_q)
    else $error("lookup token lost at the tail");

  // a miss reports zero hop and port
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (hop_q == '0) && (port_q == '0))
    else $error("miss with non-zero route data");

endmodule
`default_nettype wire

>>> tb/longest_prefix_route_lookup_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_tb
// self-checking bench for the ipv4 longest-prefix routing table
// ----------------------------------------------------------------------------
// Fills the whole table while no slot is live, then runs directed lookups
// (host route, default route, equal-mask ties, prefix bits outside the mask,
// misses) and random write/lookup traffic built around a few shared address
// bases, so that lookups often match several nested entries. The live entry
// count is changed over APB between phases, with the bench drained first.
// Every lookup transfer is scored against a shadow table in arrival order.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_tb;
  import lpr_pkg::*;

  localparam int unsigned DrainCycles = 300;       // chain length plus margin
  localparam int unsigned HoldAfter   = 500;       // lookups before the long stall
  localparam int unsigned HoldCycles  = 900;
  localparam int unsigned LimitCycles = 2_000_000;

  typedef struct {
    logic             op;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] hop;
    logic [PortW-1:0] port;
    logic [AddrW-1:0] addr;
  } route_item_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] hop;
    logic [PortW-1:0] port;
  } route_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lpr_req_if req_if ();
  lpr_rsp_if rsp_if ();

  longest_prefix_route_lookup DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if.sink),
    .out_o   (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // shadow routing table and live count
  logic [AddrW-1:0] rt_prefix [LprTableDepth];
  logic [AddrW-1:0] rt_mask   [LprTableDepth];
  logic [AddrW-1:0] rt_hop    [LprTableDepth];
  logic [PortW-1:0] rt_port   [LprTableDepth];
  logic [LiveW-1:0] live_cfg;

  route_item_t      pending_items [$];
  route_t           expected_routes [$];
  logic [AddrW-1:0] base_pool [4];

  int unsigned errors;
  int unsigned lookups_sent;
  int unsigned send_gap, send_calm;
  int unsigned take_gap, take_calm;
  int unsigned hold_left;
  logic        hold_done;
  route_t      want;

  function automatic route_t best_route(logic [AddrW-1:0] addr);
    route_t           best;
    logic [AddrW-1:0] best_mask;
    int unsigned      span;
    best      = '0;
    best_mask = '0;
    span      = (live_cfg > LprTableDepth) ? LprTableDepth : int'(live_cfg);
    for (int unsigned s = 0; s < span; s++) begin
      if ((addr & rt_mask[s]) == rt_prefix[s] && (!best.found || rt_mask[s] > best_mask)) begin
        best.found = 1'b1;
        best.hop   = rt_hop[s];
        best.port  = rt_port[s];
        best_mask  = rt_mask[s];
      end
    end
    return best;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 90);
  endfunction

  task automatic push_write(logic [IdxW-1:0] idx, logic [AddrW-1:0] prefix,
                            logic [AddrW-1:0] mask, logic [AddrW-1:0] hop,
                            logic [PortW-1:0] port);
    route_item_t it;
    it.op     = OpWrite;
    it.idx    = idx;
    it.prefix = prefix;
    it.mask   = mask;
    it.hop    = hop;
    it.port   = port;
    it.addr   = $urandom;   // ignored on a write
    pending_items.push_back(it);
  endtask

  task automatic push_lookup(logic [AddrW-1:0] addr);
    route_item_t it;
    it.op     = OpLookup;
    it.idx    = IdxW'($urandom);   // entry fields are ignored on a lookup
    it.prefix = $urandom;
    it.mask   = $urandom;
    it.hop    = $urandom;
    it.port   = PortW'($urandom);
    it.addr   = addr;
    pending_items.push_back(it);
  endtask

  // entries cluster on a few bases so that prefixes nest
  task automatic push_random_write(logic [IdxW-1:0] idx);
    int unsigned      len;
    logic [AddrW-1:0] mask, prefix;
    len  = $urandom_range(0, 32);
    mask = (len == 0) ? '0 : ('1 << (32 - len));
    if ($urandom_range(0, 9) == 0) mask = $urandom;
    prefix = base_pool[$urandom_range(0, 3)] & mask;
    if ($urandom_range(0, 9) == 0) prefix = $urandom;
    push_write(idx, prefix, mask, $urandom, PortW'($urandom));
  endtask

  task automatic push_random(int unsigned n);
    int unsigned      r, span, s;
    logic [AddrW-1:0] addr;
    span = (live_cfg > LprTableDepth) ? LprTableDepth : int'(live_cfg);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_random_write(IdxW'($urandom_range(0, LprTableDepth - 1)));
      end else begin
        if (r < 65 && span != 0) begin
          s    = $urandom_range(0, span - 1);
          addr = rt_prefix[s] | ($urandom & ~rt_mask[s]);
        end else if (r < 85) begin
          addr = base_pool[$urandom_range(0, 3)] ^ (32'($urandom) >> $urandom_range(0, 32));
        end else begin
          addr = $urandom;
        end
        push_lookup(addr);
      end
    end
  endtask

  task automatic set_live(logic [LiveW-1:0] value);
    logic [31:0] word;
    word = {23'($urandom_range(0, 8388607)), value};   // upper bits are not stored
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegLiveEntries) << 2;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    live_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(value)) begin
      errors++;
      $display("%0t: live_entries readback mismatch: expected %h, actual %h",
               $time, 32'(value), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || req_if.valid || expected_routes.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    // an item popped on the edge the loop above left may still be in flight
    while (req_if.valid || expected_routes.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic check_field(string what, logic [AddrW-1:0] exp_v, logic [AddrW-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
    end
  endtask

  // request driver, updates the shadow table on writes and scores each lookup against it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid          <= 1'b0;
      req_if.operation      <= OpWrite;
      req_if.entry_index    <= '0;
      req_if.entry_prefix   <= '0;
      req_if.entry_mask     <= '0;
      req_if.entry_gateway  <= '0;
      req_if.entry_port     <= '0;
      req_if.lookup_address <= '0;
      send_gap              <= 0;
      send_calm             <= 0;
      lookups_sent          <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (req_if.operation == OpWrite) begin
          rt_prefix[req_if.entry_index] = req_if.entry_prefix;
          rt_mask[req_if.entry_index]   = req_if.entry_mask;
          rt_hop[req_if.entry_index]    = req_if.entry_gateway;
          rt_port[req_if.entry_index]   = req_if.entry_port;
        end else begin
          expected_routes.push_back(best_route(req_if.lookup_address));
          lookups_sent <= lookups_sent + 1;
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0 && hold_left == 0) begin
          send_gap     <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          route_item_t it;
          it = pending_items.pop_front();
          req_if.valid          <= 1'b1;
          req_if.operation      <= it.op;
          req_if.entry_index    <= it.idx;
          req_if.entry_prefix   <= it.prefix;
          req_if.entry_mask     <= it.mask;
          req_if.entry_gateway  <= it.hop;
          req_if.entry_port     <= it.port;
          req_if.lookup_address <= it.addr;
          if (send_calm != 0) send_calm <= send_calm - 1;
          else if ($urandom_range(0, 99) == 0) send_calm <= $urandom_range(40, 200);
          send_gap <= (send_calm != 0) ? 0 : pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      take_gap     <= 0;
      take_calm    <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_routes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual found=%b hop=%h port=%h",
                   $time, rsp_if.route_found, rsp_if.gateway, rsp_if.out_port);
        end else begin
          want = expected_routes.pop_front();
          check_field("route_found", 32'(want.found), 32'(rsp_if.route_found));
          check_field("gateway", want.hop, rsp_if.gateway);
          check_field("out_port", 32'(want.port), 32'(rsp_if.out_port));
        end
      end
      // one long stall so the chain backs up into the request side
      if (!hold_done && lookups_sent >= HoldAfter) begin
        hold_done    <= 1'b1;
        hold_left    <= HoldCycles;
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (take_gap != 0) begin
        take_gap     <= take_gap - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (take_calm != 0) take_calm <= take_calm - 1;
        else if ($urandom_range(0, 99) == 0) take_calm <= $urandom_range(40, 200);
        take_gap <= (take_calm != 0) ? 0 : pick_gap();
      end
    end
  end

  initial begin
    #(LimitCycles * 10);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [LiveW-1:0] live_plan [6];
    int unsigned      size_plan [6];
    errors   = 0;
    live_cfg = '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    foreach (base_pool[b]) base_pool[b] = $urandom;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every slot gets written before any of it can go live
    for (int unsigned s = 0; s < LprTableDepth; s++) push_random_write(IdxW'(s));
    push_write(8'd0, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A00_0001, 4'd1);
    push_write(8'd1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0002, 4'd2);
    push_write(8'd2, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0003, 4'd3);   // tie, loses
    push_write(8'd3, 32'hC0A8_0105, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);  // host route
    push_write(8'd4, 32'h0A00_00FF, 32'hFF00_0000, 32'h0A00_0005, 4'd5);   // never matches
    push_write(8'd5, 32'hAC10_0000, 32'hFFF0_0000, 32'h0000_0000, 4'd0);
    push_write(8'd6, 32'h7F00_0000, 32'hFF00_0000, 32'h0A00_0006, 4'd6);
    push_write(8'd7, 32'hC000_0000, 32'hF000_0000, 32'h0A00_0007, 4'd7);
    push_write(8'd8, 32'h0000_0000, 32'h0000_0000, 32'h0102_0304, 4'd9);   // default route
    push_write(IdxW'(LprTableDepth - 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 4'd12);
    push_lookup(32'h0000_0000);   // nothing live yet
    push_lookup(32'hFFFF_FFFF);
    drain();

    set_live(9'd8);
    push_lookup(32'hC0A8_0105);
    push_lookup(32'hC0A8_0163);
    push_lookup(32'hC0A8_FF01);
    push_lookup(32'h0A00_00FF);
    push_lookup(32'hAC1F_FFFF);
    push_lookup(32'hC123_4567);
    push_lookup(32'h0000_0000);
    push_lookup(32'hFFFF_FFFF);
    drain();

    set_live(9'd9);
    push_lookup(32'h0000_0000);
    push_lookup(32'h0A00_00FF);
    push_lookup(32'hFFFF_FFFF);
    drain();

    live_plan = '{9'd256, 9'd511, 9'd300, 9'($urandom_range(0, 511)), 9'd1, 9'd0};
    size_plan = '{450, 300, 250, 250, 150, 100};
    foreach (live_plan[p]) begin
      set_live(live_plan[p]);
      push_random(size_plan[p]);
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/lpr_pkg.sv
rtl/lpr_intf.sv
rtl/lpr_cell.sv
rtl/lpr_outreg.sv
rtl/longest_prefix_route_lookup.sv
tb/longest_prefix_route_lookup_tb.sv
